>>> rtl/wrpc_pkg.sv
// Shared widths, codes and register defaults for the wheel rate controller.
package wrpc_pkg;

  // Default fixed-point formats of the rate samples and the gains.
  localparam int unsigned RATE_FRAC_BITS_DEF = 12;
  localparam int unsigned GAIN_FRAC_BITS_DEF = 8;

  // Field and datapath widths.
  localparam int unsigned RATE_W = 16;  // yaw rate sample
  localparam int unsigned GAIN_W = 16;  // PID gains
  localparam int unsigned E_W    = 17;  // error, the negated rate
  localparam int unsigned ES_W   = 20;  // clamped error sum
  localparam int unsigned D_W    = 18;  // error difference
  localparam int unsigned ACC_W  = 38;  // PID accumulator
  localparam int unsigned PROD_W = 42;  // accumulator times the output scale
  localparam int unsigned BRK_W  = 20;  // five times the rate
  localparam int unsigned SPD_W  = 8;   // wheel speed
  localparam int unsigned LIM_W  = 7;   // speed style limits

  // Configuration port.
  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  // Register indexes.
  localparam logic [2:0] REG_GAIN_PROP   = 3'd0;
  localparam logic [2:0] REG_GAIN_INTEG  = 3'd1;
  localparam logic [2:0] REG_GAIN_DERIV  = 3'd2;
  localparam logic [2:0] REG_INTEG_LIMIT = 3'd3;
  localparam logic [2:0] REG_DEAD_BAND   = 3'd4;
  localparam logic [2:0] REG_SPEED_LIMIT = 3'd5;
  localparam logic [2:0] REG_BRAKE_LIMIT = 3'd6;
  localparam logic [2:0] REG_SETTLE_RATE = 3'd7;

  // Register reset values.
  localparam logic [15:0] GAIN_PROP_RST   = 16'd256;
  localparam logic [15:0] GAIN_INTEG_RST  = 16'd26;
  localparam logic [15:0] GAIN_DERIV_RST  = 16'd13;
  localparam logic [18:0] INTEG_LIMIT_RST = 19'd409600;
  localparam logic [6:0]  DEAD_BAND_RST   = 7'd5;
  localparam logic [6:0]  SPEED_LIMIT_RST = 7'd127;
  localparam logic [6:0]  BRAKE_LIMIT_RST = 7'd50;
  localparam logic [14:0] SETTLE_RATE_RST = 15'd2048;

  // Request modes.
  localparam logic [1:0] MODE_HOLD     = 2'd1;
  localparam logic [1:0] MODE_DETUMBLE = 2'd2;

  // Command kinds.
  localparam logic [1:0] CMD_SELECT = 2'd0;
  localparam logic [1:0] CMD_SPEED  = 2'd1;
  localparam logic [1:0] CMD_STOP   = 2'd2;

endpackage

>>> rtl/wrpc_mac.sv
// Bit-serial multiply-accumulate unit for the three PID terms.
module wrpc_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [wrpc_pkg::E_W-1:0]     e_i,
  input  logic signed [wrpc_pkg::ES_W-1:0]    es_i,
  input  logic signed [wrpc_pkg::D_W-1:0]     d_i,
  input  logic        [wrpc_pkg::GAIN_W-1:0]  gp_i,
  input  logic        [wrpc_pkg::GAIN_W-1:0]  gi_i,
  input  logic        [wrpc_pkg::GAIN_W-1:0]  gd_i,
  output logic                                done_o,
  output logic signed [wrpc_pkg::ACC_W-1:0]   acc_o
);
  import wrpc_pkg::*;

  localparam int unsigned CNT_W = $clog2(GAIN_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_W - 1);

  logic                    run_q, run_d;
  logic                    done_q, done_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] e_q, e_d;
  logic signed [ACC_W-1:0] es_q, es_d;
  logic signed [ACC_W-1:0] d_q, d_d;
  logic [GAIN_W-1:0]       gp_q, gp_d;
  logic [GAIN_W-1:0]       gi_q, gi_d;
  logic [GAIN_W-1:0]       gd_q, gd_d;

  // One gain bit per cycle, most significant first: shift the sum up and add
  // each operand whose gain bit is set.
  always_comb begin
    logic signed [ACC_W-1:0] add_p;
    logic signed [ACC_W-1:0] add_i;
    logic signed [ACC_W-1:0] add_d;
    add_p  = gp_q[GAIN_W-1] ? e_q  : '0;
    add_i  = gi_q[GAIN_W-1] ? es_q : '0;
    add_d  = gd_q[GAIN_W-1] ? d_q  : '0;
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    e_d    = e_q;
    es_d   = es_q;
    d_d    = d_q;
    gp_d   = gp_q;
    gi_d   = gi_q;
    gd_d   = gd_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      acc_d = '0;
      e_d   = {{(ACC_W-E_W){e_i[E_W-1]}}, e_i};
      es_d  = {{(ACC_W-ES_W){es_i[ES_W-1]}}, es_i};
      d_d   = {{(ACC_W-D_W){d_i[D_W-1]}}, d_i};
      gp_d  = gp_i;
      gi_d  = gi_i;
      gd_d  = gd_i;
    end else if (run_q) begin
      acc_d = (acc_q <<< 1) + add_p + add_i + add_d;
      gp_d  = {gp_q[GAIN_W-2:0], 1'b0};
      gi_d  = {gi_q[GAIN_W-2:0], 1'b0};
      gd_d  = {gd_q[GAIN_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand shift registers and accumulator.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    e_q   <= e_d;
    es_q  <= es_d;
    d_q   <= d_d;
    gp_q  <= gp_d;
    gi_q  <= gi_d;
    gd_q  <= gd_d;
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

>>> rtl/wheel_rate_pid_controller_top.sv
// Wheel rate controller top level: register port, sequencer and result register.
//
// Usage: each input word carries a mode, a yaw-rate sample and two sensor
// status flags. The word is taken at a rising edge with in_valid_i high and
// in_stall_o low. It yields zero, one or two result words on the output
// channel, taken at an edge with out_valid_o high and out_stall_i low; last_o
// marks the final word of an input word.
// Sequence: a start-up or stop word goes from the emit state to the output register.
// A detumble word passes the brake, shape and emit states; a settled one then emits
// its stop word. A rate-hold word passes prep, multiply, scale, divide, shape and
// emit, paced by the bit-serial MAC unit walking the 16 gain bits one per cycle.
// Throughput: one input word at a time; a new word is accepted once the last
// result of the previous one sits in the output register, even while the
// receiver still stalls it.
// A stalled result holds its value; the sequencer waits for the register to
// free up before loading the next word.
// Reset clears the controller state and loads the default gains and limits;
// the first word after reset always produces the select-motor command.
module wheel_rate_pid_controller_top #(
  parameter int unsigned RATE_FRAC_BITS = wrpc_pkg::RATE_FRAC_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS = wrpc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wrpc_pkg::CFG_AW-1:0]     paddr,
  input  logic [wrpc_pkg::CFG_DW-1:0]     pwdata,
  output logic [wrpc_pkg::CFG_DW-1:0]     prdata,
  output logic                            pready,
  // Input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      req_type_i,
  input  logic signed [15:0]              yaw_rate_i,
  input  logic                            imu_ready_i,
  input  logic                            read_ok_i,
  // Output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      cmd_kind_o,
  output logic signed [7:0]               wheel_speed_o,
  output logic                            running_o,
  output logic                            last_o
);
  import wrpc_pkg::*;

  localparam int unsigned SHIFT = RATE_FRAC_BITS + GAIN_FRAC_BITS;
  localparam logic signed [PROD_W-1:0] DIV_BIAS = PROD_W'((64'd1 << SHIFT) - 64'd1);
  localparam logic signed [BRK_W-1:0] BRK_BIAS = BRK_W'((64'd1 << RATE_FRAC_BITS) - 64'd1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PREP  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_SCALE = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_BRAKE = 8'b0010_0000,
    S_SHAPE = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] gain_prop_q, gain_integ_q, gain_deriv_q;
  logic [18:0] integ_limit_q;
  logic [6:0]  dead_band_q, speed_limit_q, brake_limit_q;
  logic [14:0] settle_rate_q;
  logic        cfg_we;

  // Controller state.
  logic                     started_q, started_d;
  logic                     motor_on_q, motor_on_d;
  logic signed [ES_W-1:0]   err_sum_q, err_sum_d;
  logic signed [E_W-1:0]    prev_err_q, prev_err_d;
  logic signed [RATE_W-1:0] held_q, held_d;
  logic                     hold_q, hold_d;
  logic                     settled_q, settled_d;
  logic                     two_q, two_d;
  logic signed [PROD_W-1:0] val_q, val_d;

  // Pending result and output register.
  logic [1:0]              res_kind_q, res_kind_d;
  logic signed [SPD_W-1:0] res_speed_q, res_speed_d;
  logic                    res_run_q, res_run_d;
  logic                    res_last_q, res_last_d;
  logic                    out_valid_q, out_valid_d;
  logic [1:0]              out_kind_q, out_kind_d;
  logic signed [SPD_W-1:0] out_speed_q, out_speed_d;
  logic                    out_run_q, out_run_d;
  logic                    out_last_q, out_last_d;

  // PID datapath.
  logic signed [E_W-1:0]    e_cur;
  logic signed [ES_W:0]     es_sum;
  logic signed [ES_W:0]     es_lim;
  logic signed [ES_W-1:0]   es_new;
  logic signed [D_W-1:0]    d_cur;
  logic                     mac_start;
  logic                     mac_done;
  logic signed [ACC_W-1:0]  mac_acc;

  // Detumble and shaping datapath.
  logic signed [BRK_W-1:0]  brk_neg;
  logic signed [BRK_W-1:0]  brk_trunc;
  logic signed [BRK_W-1:0]  brk_lim;
  logic signed [BRK_W-1:0]  brk_clamp;
  logic signed [E_W-1:0]    held_abs;
  logic signed [PROD_W-1:0] db_s;
  logic signed [PROD_W-1:0] sl_s;
  logic signed [SPD_W-1:0]  shaped;
  logic signed [RATE_W-1:0] held_sel;
  logic                     out_free;

  // Register port: writes land in the access phase, reads are immediate.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q   <= GAIN_PROP_RST;
      gain_integ_q  <= GAIN_INTEG_RST;
      gain_deriv_q  <= GAIN_DERIV_RST;
      integ_limit_q <= INTEG_LIMIT_RST;
      dead_band_q   <= DEAD_BAND_RST;
      speed_limit_q <= SPEED_LIMIT_RST;
      brake_limit_q <= BRAKE_LIMIT_RST;
      settle_rate_q <= SETTLE_RATE_RST;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_GAIN_PROP:   gain_prop_q   <= pwdata[15:0];
        REG_GAIN_INTEG:  gain_integ_q  <= pwdata[15:0];
        REG_GAIN_DERIV:  gain_deriv_q  <= pwdata[15:0];
        REG_INTEG_LIMIT: integ_limit_q <= pwdata[18:0];
        REG_DEAD_BAND:   dead_band_q   <= pwdata[6:0];
        REG_SPEED_LIMIT: speed_limit_q <= pwdata[6:0];
        REG_BRAKE_LIMIT: brake_limit_q <= pwdata[6:0];
        REG_SETTLE_RATE: settle_rate_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_GAIN_PROP:   prdata = {16'd0, gain_prop_q};
      REG_GAIN_INTEG:  prdata = {16'd0, gain_integ_q};
      REG_GAIN_DERIV:  prdata = {16'd0, gain_deriv_q};
      REG_INTEG_LIMIT: prdata = {13'd0, integ_limit_q};
      REG_DEAD_BAND:   prdata = {25'd0, dead_band_q};
      REG_SPEED_LIMIT: prdata = {25'd0, speed_limit_q};
      REG_BRAKE_LIMIT: prdata = {25'd0, brake_limit_q};
      REG_SETTLE_RATE: prdata = {17'd0, settle_rate_q};
      default:         prdata = '0;
    endcase
  end

  // Rate selection: a missing sensor reads as zero, a failed read keeps the old rate.
  assign held_sel = !imu_ready_i ? '0 : (read_ok_i ? yaw_rate_i : held_q);

  // PID operands: error, clamped error sum and error difference.
  assign e_cur  = -{held_q[RATE_W-1], held_q};
  assign es_sum = {err_sum_q[ES_W-1], err_sum_q} + {{(ES_W+1-E_W){e_cur[E_W-1]}}, e_cur};
  assign es_lim = {2'b00, integ_limit_q};

  always_comb begin
    if (es_sum > es_lim) begin
      es_new = es_lim[ES_W-1:0];
    end else if (es_sum < -es_lim) begin
      es_new = ES_W'(-es_lim);
    end else begin
      es_new = es_sum[ES_W-1:0];
    end
  end

  assign d_cur = {e_cur[E_W-1], e_cur} - {prev_err_q[E_W-1], prev_err_q};

  wrpc_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .e_i     (e_cur),
    .es_i    (es_new),
    .d_i     (d_cur),
    .gp_i    (gain_prop_q),
    .gi_i    (gain_integ_q),
    .gd_i    (gain_deriv_q),
    .done_o  (mac_done),
    .acc_o   (mac_acc)
  );

  // Detumble brake: minus five times the rate, truncated toward zero, then limited.
  assign brk_neg   = -(({{(BRK_W-RATE_W){held_q[RATE_W-1]}}, held_q} <<< 2)
                     + {{(BRK_W-RATE_W){held_q[RATE_W-1]}}, held_q});
  assign brk_trunc = $signed(brk_neg + (brk_neg[BRK_W-1] ? BRK_BIAS : '0)) >>> RATE_FRAC_BITS;
  assign brk_lim   = {{(BRK_W-LIM_W){1'b0}}, brake_limit_q};

  always_comb begin
    if (brk_trunc > brk_lim) begin
      brk_clamp = brk_lim;
    end else if (brk_trunc < -brk_lim) begin
      brk_clamp = -brk_lim;
    end else begin
      brk_clamp = brk_trunc;
    end
  end

  assign held_abs = held_q[RATE_W-1] ? -{held_q[RATE_W-1], held_q}
                                     : {held_q[RATE_W-1], held_q};

  // Speed shaping: dead band, then the symmetric speed limit.
  assign db_s = {{(PROD_W-LIM_W){1'b0}}, dead_band_q};
  assign sl_s = {{(PROD_W-LIM_W){1'b0}}, speed_limit_q};

  always_comb begin
    if (val_q <= db_s && val_q >= -db_s) begin
      shaped = '0;
    end else if (val_q > sl_s) begin
      shaped = sl_s[SPD_W-1:0];
    end else if (val_q < -sl_s) begin
      shaped = SPD_W'(-sl_s);
    end else begin
      shaped = val_q[SPD_W-1:0];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    started_d   = started_q;
    motor_on_d  = motor_on_q;
    err_sum_d   = err_sum_q;
    prev_err_d  = prev_err_q;
    held_d      = held_q;
    hold_d      = hold_q;
    settled_d   = settled_q;
    two_d       = two_q;
    val_d       = val_q;
    res_kind_d  = res_kind_q;
    res_speed_d = res_speed_q;
    res_run_d   = res_run_q;
    res_last_d  = res_last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_speed_d = out_speed_q;
    out_run_d   = out_run_q;
    out_last_d  = out_last_q;
    mac_start   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!started_q) begin
            // First word after reset: clear the loop and select the motor.
            started_d   = 1'b1;
            motor_on_d  = 1'b0;
            err_sum_d   = '0;
            prev_err_d  = '0;
            res_kind_d  = CMD_SELECT;
            res_speed_d = '0;
            res_run_d   = 1'b0;
            res_last_d  = 1'b1;
            two_d       = 1'b0;
            state_d     = S_EMIT;
          end else if (req_type_i != MODE_HOLD && req_type_i != MODE_DETUMBLE) begin
            // Inactive: stop a running motor, otherwise nothing to say.
            if (motor_on_q) begin
              motor_on_d  = 1'b0;
              res_kind_d  = CMD_STOP;
              res_speed_d = '0;
              res_run_d   = 1'b0;
              res_last_d  = 1'b1;
              two_d       = 1'b0;
              state_d     = S_EMIT;
            end
          end else begin
            held_d  = held_sel;
            hold_d  = (req_type_i == MODE_HOLD);
            state_d = (req_type_i == MODE_HOLD) ? S_PREP : S_BRAKE;
          end
        end
      end
      S_PREP: begin
        mac_start  = 1'b1;
        err_sum_d  = es_new;
        prev_err_d = e_cur;
        state_d    = S_MUL;
      end
      S_MUL: begin
        if (mac_done) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        // Output scale of ten as eight plus two.
        val_d   = ({{(PROD_W-ACC_W){mac_acc[ACC_W-1]}}, mac_acc} <<< 3)
                + ({{(PROD_W-ACC_W){mac_acc[ACC_W-1]}}, mac_acc} <<< 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        // Drop the fraction bits, rounding toward zero.
        val_d   = $signed(val_q + (val_q[PROD_W-1] ? DIV_BIAS : '0)) >>> SHIFT;
        state_d = S_SHAPE;
      end
      S_BRAKE: begin
        val_d     = {{(PROD_W-BRK_W){brk_clamp[BRK_W-1]}}, brk_clamp};
        settled_d = (held_abs < $signed({2'b00, settle_rate_q}));
        state_d   = S_SHAPE;
      end
      S_SHAPE: begin
        res_kind_d  = CMD_SPEED;
        res_speed_d = shaped;
        res_run_d   = (shaped != '0);
        res_last_d  = hold_q || !settled_q;
        two_d       = !hold_q && settled_q;
        motor_on_d  = (!hold_q && settled_q) ? 1'b0 : (shaped != '0);
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = res_kind_q;
          out_speed_d = res_speed_q;
          out_run_d   = res_run_q;
          out_last_d  = res_last_q;
          if (two_q) begin
            // A settled detumble follows its speed word with a stop.
            res_kind_d  = CMD_STOP;
            res_speed_d = '0;
            res_run_d   = 1'b0;
            res_last_d  = 1'b1;
            two_d       = 1'b0;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= 1'b0;
      motor_on_q  <= 1'b0;
      err_sum_q   <= '0;
      prev_err_q  <= '0;
      held_q      <= '0;
      two_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      motor_on_q  <= motor_on_d;
      err_sum_q   <= err_sum_d;
      prev_err_q  <= prev_err_d;
      held_q      <= held_d;
      two_q       <= two_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and result words.
  always_ff @(posedge clk_i) begin
    hold_q      <= hold_d;
    settled_q   <= settled_d;
    val_q       <= val_d;
    res_kind_q  <= res_kind_d;
    res_speed_q <= res_speed_d;
    res_run_q   <= res_run_d;
    res_last_q  <= res_last_d;
    out_kind_q  <= out_kind_d;
    out_speed_q <= out_speed_d;
    out_run_q   <= out_run_d;
    out_last_q  <= out_last_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cmd_kind_o    = out_kind_q;
  assign wheel_speed_o = out_speed_q;
  assign running_o     = out_run_q;
  assign last_o        = out_last_q;

endmodule
